// ----- src/rau_pkg.sv -----
// Package: shared constants, action and status codes for the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int WORD_W = 64;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  typedef struct packed {
    logic start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- src/rau_divider.sv -----
// Shared restoring divider: one quotient bit per cycle, 64-bit unsigned.
module rau_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  rau_pkg::div_req_t             req,
  output logic                          done,
  output logic [rau_pkg::WORD_W-1:0]    quot,
  output logic [rau_pkg::WORD_W-1:0]    rem
);

  localparam int W = rau_pkg::WORD_W;
  localparam int CW = $clog2(W + 1);

  logic            active;
  logic [CW-1:0]   count;
  logic [W-1:0]    divisor;
  logic [W:0]      trial;
  logic [W:0]      shifted;

  assign shifted = {rem, quot[W-1]};
  assign trial = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        count <= CW'(W);
        quot <= req.dividend;
        rem <= '0;
        divisor <= req.divisor;
      end else if (active) begin
        if (trial[W]) begin
          rem <= shifted[W-1:0];
          quot <= {quot[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          quot <= {quot[W-2:0], 1'b1};
        end
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/rau_sequencer.sv -----
// Sequencer: operand reduction, GCD, LCM, arithmetic and result forming over the shared divider.
module rau_sequencer #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [2:0]                   action,
  input  logic [OPERAND_WIDTH-1:0]     num_a,
  input  logic [OPERAND_WIDTH-1:0]     den_a,
  input  logic [OPERAND_WIDTH-1:0]     num_b,
  input  logic [OPERAND_WIDTH-1:0]     den_b,
  output logic                         busy,
  output logic                         done,
  output logic signed [63:0]           num_out,
  output logic [62:0]                  den_out,
  output logic signed [1:0]            order,
  output logic [1:0]                   status,
  output rau_pkg::div_req_t            dreq,
  input  logic                         ddone,
  input  logic [rau_pkg::WORD_W-1:0]   dquot,
  input  logic [rau_pkg::WORD_W-1:0]   drem
);

  localparam int W = rau_pkg::WORD_W;

  typedef enum logic [4:0] {
    S_IDLE, S_GCD_START, S_GCD_WAIT, S_RED_N, S_RED_N_WAIT, S_RED_D, S_RED_D_WAIT,
    S_DISPATCH, S_CMP_MUL, S_CMP_DONE, S_LCM_Q, S_LCM_Q_WAIT, S_LCM_MUL, S_LCM_FA,
    S_LCM_FA_WAIT, S_LCM_FB, S_LCM_FB_WAIT, S_TERM_A, S_TERM_B, S_SUM, S_MUL_N,
    S_MUL_D, S_OUT
  } state_t;

  // reduction return points
  typedef enum logic [1:0] {
    RET_A, RET_B, RET_R
  } ret_t;

  state_t        state;
  ret_t          ret;
  logic [2:0]    act;
  logic          neg_a, neg_b, neg_r;
  logic [W-1:0]  mag_a, den_a_r, mag_b, den_b_r, mag_r, den_r;
  logic [W-1:0]  gx, gy, gval, lcm, term_a;
  logic [W-1:0]  red_m, red_d;
  logic          red_neg;
  logic [W-1:0]  mul_x, mul_y;
  logic [W-1:0]  mul_p;
  logic          gcd_lcm;

  logic          sna, sda, snb, sdb;
  logic [W-1:0]  ma, da, mb, db;
  logic          cmp_lt, cmp_gt;

  function automatic logic [W-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    logic [OPERAND_WIDTH-1:0] n;
    n = v[OPERAND_WIDTH-1] ? (~v + OPERAND_WIDTH'(1)) : v;
    return W'(n) | (v[OPERAND_WIDTH-1] && (n == '0) ? (W'(1) << (OPERAND_WIDTH-1)) : '0);
  endfunction

  assign sna = num_a[OPERAND_WIDTH-1];
  assign sda = den_a[OPERAND_WIDTH-1];
  assign snb = num_b[OPERAND_WIDTH-1];
  assign sdb = den_b[OPERAND_WIDTH-1];
  assign ma = mag_of(num_a);
  assign da = mag_of(den_a);
  assign mb = mag_of(num_b);
  assign db = mag_of(den_b);

  // operands of each product stay within 32 bits after reduction
  assign mul_p = W'(mul_x[31:0]) * W'(mul_y[31:0]);

  assign busy = (state != S_IDLE);

  always_comb begin
    logic signed [W:0] l, r;
    l = neg_a ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    r = neg_b ? -$signed({1'b0, den_r}) : $signed({1'b0, den_r});
    cmp_lt = l < r;
    cmp_gt = l > r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      done <= 1'b0;
      dreq.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            act <= action;
            num_out <= '0;
            den_out <= '0;
            order <= rau_pkg::ORD_EQ;
            status <= rau_pkg::ST_OK;
            if (action > rau_pkg::ACT_CMP || da == '0 || db == '0) begin
              status <= rau_pkg::ST_INVALID;
              done <= 1'b1;
            end else begin
              neg_a <= sna ^ sda;
              neg_b <= snb ^ sdb;
              mag_a <= ma;
              den_a_r <= da;
              mag_b <= mb;
              den_b_r <= db;
              red_m <= ma;
              red_d <= da;
              red_neg <= sna ^ sda;
              ret <= RET_A;
              gcd_lcm <= 1'b0;
              gx <= ma;
              gy <= da;
              state <= S_GCD_START;
            end
          end
        end
        S_GCD_START: begin
          if (gy == '0) begin
            gval <= gx;
            state <= gcd_lcm ? S_LCM_Q : S_RED_N;
          end else begin
            dreq.start <= 1'b1;
            dreq.dividend <= gx;
            dreq.divisor <= gy;
            state <= S_GCD_WAIT;
          end
        end
        S_GCD_WAIT: begin
          if (ddone) begin
            gx <= gy;
            gy <= drem;
            state <= S_GCD_START;
          end
        end
        S_RED_N: begin
          dreq.start <= 1'b1;
          dreq.dividend <= red_m;
          dreq.divisor <= gval;
          state <= S_RED_N_WAIT;
        end
        S_RED_N_WAIT: begin
          if (ddone) begin
            red_m <= dquot;
            state <= S_RED_D;
          end
        end
        S_RED_D: begin
          dreq.start <= 1'b1;
          dreq.dividend <= red_d;
          dreq.divisor <= gval;
          state <= S_RED_D_WAIT;
        end
        S_RED_D_WAIT: begin
          if (ddone) begin
            if (red_m == '0) begin
              red_neg <= 1'b0;
              red_d <= W'(1);
            end else begin
              red_d <= dquot;
            end
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (ret)
            RET_A: begin
              neg_a <= red_neg;
              mag_a <= red_m;
              den_a_r <= red_d;
              red_m <= mag_b;
              red_d <= den_b_r;
              red_neg <= neg_b;
              gx <= mag_b;
              gy <= den_b_r;
              ret <= RET_B;
              state <= S_GCD_START;
            end
            RET_B: begin
              neg_b <= red_neg;
              mag_b <= red_m;
              den_b_r <= red_d;
              if (act == rau_pkg::ACT_CMP) begin
                mul_x <= mag_a;
                mul_y <= red_d;
                state <= S_CMP_MUL;
              end else if (act == rau_pkg::ACT_DIV && red_m == '0) begin
                status <= rau_pkg::ST_DIVZERO;
                done <= 1'b1;
                state <= S_IDLE;
              end else if (act == rau_pkg::ACT_MUL) begin
                mul_x <= mag_a;
                mul_y <= red_m;
                neg_r <= neg_a ^ red_neg;
                state <= S_MUL_N;
              end else if (act == rau_pkg::ACT_DIV) begin
                mul_x <= mag_a;
                mul_y <= red_d;
                neg_r <= neg_a ^ red_neg;
                state <= S_MUL_N;
              end else begin
                if (act == rau_pkg::ACT_SUB) begin
                  neg_b <= ~red_neg;
                end
                gcd_lcm <= 1'b1;
                gx <= den_a_r;
                gy <= red_d;
                state <= S_GCD_START;
              end
            end
            default: begin
              mag_r <= red_m;
              den_r <= red_d;
              neg_r <= red_neg;
              state <= S_OUT;
            end
          endcase
        end
        S_CMP_MUL: begin
          mag_r <= mul_p;
          mul_x <= mag_b;
          mul_y <= den_a_r;
          state <= S_CMP_DONE;
        end
        S_CMP_DONE: begin
          den_r <= mul_p;
          state <= S_OUT;
          act <= rau_pkg::ACT_CMP;
          ret <= RET_A;
        end
        S_LCM_Q: begin
          dreq.start <= 1'b1;
          dreq.dividend <= den_a_r;
          dreq.divisor <= gval;
          state <= S_LCM_Q_WAIT;
        end
        S_LCM_Q_WAIT: begin
          if (ddone) begin
            mul_x <= dquot;
            mul_y <= den_b_r;
            state <= S_LCM_MUL;
          end
        end
        S_LCM_MUL: begin
          lcm <= mul_p;
          dreq.start <= 1'b1;
          dreq.dividend <= mul_p;
          dreq.divisor <= den_a_r;
          state <= S_LCM_FA_WAIT;
        end
        S_LCM_FA: begin
          state <= S_LCM_FA_WAIT;
        end
        S_LCM_FA_WAIT: begin
          if (ddone) begin
            mul_x <= mag_a;
            mul_y <= dquot;
            state <= S_TERM_A;
          end
        end
        S_TERM_A: begin
          term_a <= mul_p;
          dreq.start <= 1'b1;
          dreq.dividend <= lcm;
          dreq.divisor <= den_b_r;
          state <= S_LCM_FB_WAIT;
        end
        S_LCM_FB: begin
          state <= S_LCM_FB_WAIT;
        end
        S_LCM_FB_WAIT: begin
          if (ddone) begin
            mul_x <= mag_b;
            mul_y <= dquot;
            state <= S_TERM_B;
          end
        end
        S_TERM_B: begin
          mul_x <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          red_d <= lcm;
          ret <= RET_R;
          gcd_lcm <= 1'b0;
          gy <= lcm;
          if (neg_a == neg_b) begin
            red_m <= term_a + mul_x;
            gx <= term_a + mul_x;
            red_neg <= neg_a;
          end else if (term_a >= mul_x) begin
            red_m <= term_a - mul_x;
            gx <= term_a - mul_x;
            red_neg <= neg_a;
          end else begin
            red_m <= mul_x - term_a;
            gx <= mul_x - term_a;
            red_neg <= neg_b;
          end
          state <= S_GCD_START;
        end
        S_MUL_N: begin
          red_m <= mul_p;
          gx <= mul_p;
          mul_x <= den_a_r;
          mul_y <= (act == rau_pkg::ACT_MUL) ? den_b_r : mag_b;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          red_d <= mul_p;
          gy <= mul_p;
          red_neg <= neg_r;
          ret <= RET_R;
          gcd_lcm <= 1'b0;
          state <= S_GCD_START;
        end
        S_OUT: begin
          if (act == rau_pkg::ACT_CMP) begin
            order <= cmp_lt ? rau_pkg::ORD_LT : (cmp_gt ? rau_pkg::ORD_GT : rau_pkg::ORD_EQ);
          end else begin
            num_out <= neg_r ? -$signed({1'b0, mag_r[62:0]}) : $signed({1'b0, mag_r[62:0]});
            den_out <= den_r[62:0];
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/rational_arithmetic_unit.sv -----
// Top level: rational arithmetic unit with a command interface.
// One item is accepted when start is high and busy is low; unless the item is rejected, busy
// then stays high until the result appears for a single cycle with done high. The receiver
// cannot stall. An item's run time depends on the data: each division runs on the shared
// bit-serial divider, and the Euclidean steps and reductions each need divisions; items
// rejected for an invalid action or zero denominator get done high without busy rising.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            action,
  input  logic signed [31:0]    num_a,
  input  logic signed [31:0]    den_a,
  input  logic signed [31:0]    num_b,
  input  logic signed [31:0]    den_b,
  output logic                  done,
  output logic signed [63:0]    num_out,
  output logic [62:0]           den_out,
  output logic signed [1:0]     order,
  output logic [1:0]            status
);

  rau_pkg::div_req_t                dreq;
  logic                             ddone;
  logic [rau_pkg::WORD_W-1:0]       dquot;
  logic [rau_pkg::WORD_W-1:0]       drem;

  rau_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quot (dquot),
    .rem  (drem)
  );

  rau_sequencer #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .action  (action),
    .num_a   (num_a[OPERAND_WIDTH-1:0]),
    .den_a   (den_a[OPERAND_WIDTH-1:0]),
    .num_b   (num_b[OPERAND_WIDTH-1:0]),
    .den_b   (den_b[OPERAND_WIDTH-1:0]),
    .busy    (busy),
    .done    (done),
    .num_out (num_out),
    .den_out (den_out),
    .order   (order),
    .status  (status),
    .dreq    (dreq),
    .ddone   (ddone),
    .dquot   (dquot),
    .drem    (drem)
  );

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != rau_pkg::ST_OK |-> num_out == '0 && den_out == '0 && order == '0)
    else $error("error result not cleared");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    done && status == rau_pkg::ST_OK && order == '0 && num_out != '0 |-> den_out != '0)
    else $error("zero denominator on success");
`endif

endmodule
